>>> rtl/tpae_pkg.sv
// Shared constants, types and functions for the antenna pointing pipeline.
package tpae_pkg;

	localparam int CORDIC_STAGES = 16;
	localparam int ATAN_LEN = 24;
	localparam int CW = 44;
	localparam logic signed [16:0] GAIN_Z_MUL = 17'sd53961;

	typedef enum logic [1:0] {
		REG_AZ_LEFT,
		REG_AZ_RIGHT,
		REG_EL_LOWER,
		REG_EL_UPPER
	} reg_idx_t;

	// Values that ride alongside a vector through a CORDIC pipeline.
	typedef struct packed {
		logic                 trk;
		logic [15:0]          az;
		logic signed [CW-1:0] zz;
	} side_t;

	localparam logic [31:0] ATAN_TAB [0:ATAN_LEN-1] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
		32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
		32'd166886, 32'd83443, 32'd41722, 32'd20861,
		32'd10430, 32'd5215, 32'd2608, 32'd1304,
		32'd652, 32'd326, 32'd163, 32'd81
	};

	// Rounds a 32-bit angle (2^31 = pi) to 16-bit binary angle units.
	function automatic logic [15:0] to_bau(input logic [31:0] ang);
		logic [31:0] r;
		r = ang + 32'h0000_8000;
		return r[31:16];
	endfunction

endpackage

>>> rtl/tpae_cordic.sv
// Pipelined CORDIC vectoring unit: one pre-rotation stage and one stage per iteration.
module tpae_cordic (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [tpae_pkg::CW-1:0] in_x,
	input  logic signed [tpae_pkg::CW-1:0] in_y,
	input  tpae_pkg::side_t               in_side,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [tpae_pkg::CW-1:0] out_mag,
	output logic [31:0]                   out_ang,
	output tpae_pkg::side_t               out_side
);
	import tpae_pkg::*;

	localparam int N = CORDIC_STAGES;

	logic                 vld_s  [0:N];
	logic                 rdy    [0:N+1];
	logic signed [CW-1:0] x_s    [0:N];
	logic signed [CW-1:0] y_s    [0:N];
	logic [31:0]          ang_s  [0:N];
	logic                 zero_s [0:N];
	side_t                side_s [0:N];

	assign rdy[N+1] = out_ready;
	assign in_ready = rdy[0];

	// Pre-rotation: a vector in the left half-plane is turned through pi.
	assign rdy[0] = !vld_s[0] || rdy[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (rdy[0]) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[0] && in_valid) begin
			zero_s[0] <= (in_x == '0) && (in_y == '0);
			side_s[0] <= in_side;
			if (in_x[CW-1]) begin
				x_s[0]   <= -in_x;
				y_s[0]   <= -in_y;
				ang_s[0] <= 32'h8000_0000;
			end else begin
				x_s[0]   <= in_x;
				y_s[0]   <= in_y;
				ang_s[0] <= '0;
			end
		end
	end

	for (genvar k = 1; k <= N; k++) begin : g_stage
		logic signed [CW-1:0] xs;
		logic signed [CW-1:0] ys;

		assign xs = x_s[k-1] >>> (k - 1);
		assign ys = y_s[k-1] >>> (k - 1);
		assign rdy[k] = !vld_s[k] || rdy[k+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k] && vld_s[k-1]) begin
				zero_s[k] <= zero_s[k-1];
				side_s[k] <= side_s[k-1];
				if (!y_s[k-1][CW-1]) begin
					x_s[k]   <= x_s[k-1] + ys;
					y_s[k]   <= y_s[k-1] - xs;
					ang_s[k] <= ang_s[k-1] + ATAN_TAB[k-1];
				end else begin
					x_s[k]   <= x_s[k-1] - ys;
					y_s[k]   <= y_s[k-1] + xs;
					ang_s[k] <= ang_s[k-1] - ATAN_TAB[k-1];
				end
			end
		end
	end

	assign out_valid = vld_s[N];
	assign out_mag   = x_s[N];
	assign out_ang   = zero_s[N] ? 32'h0000_0000 : ang_s[N];
	assign out_side  = side_s[N];

endmodule

>>> rtl/track_pointing_az_el.sv
// Top level: antenna reference azimuth and elevation toward a tracked target.
// An accepted item passes through stage 1, stage 2, the azimuth CORDIC, the elevation CORDIC and the output register.
// Throughput: one item per cycle while the output is not held; each CORDIC iteration has a pipeline stage of its own.
// Every stage holds under back-pressure, so a stalled result loses and repeats nothing.
// Reset clears all valid bits and returns the limit registers to the full angular range.
module track_pointing_az_el (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// rel_north[23:0], rel_east[47:24], rel_down[71:48], heading_sin[87:72],
	// heading_cos[103:88]
	input  logic [103:0] s_tdata,
	// have_track[0]
	input  logic         s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// ref_azimuth[15:0], ref_elevation[31:16]
	output logic [31:0]  m_tdata,
	// scan_mode[0]
	output logic         m_tuser,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);
	import tpae_pkg::*;

	// Configuration registers. Each sits at byte address 4*i; the low two
	// address bits are not decoded.
	logic signed [15:0] az_left_q;
	logic signed [15:0] az_right_q;
	logic signed [15:0] el_lower_q;
	logic signed [15:0] el_upper_q;
	logic               cfg_wr;
	reg_idx_t           cfg_idx;

	assign pready  = 1'b1;
	assign cfg_idx = reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			az_left_q  <= -16'sd32768;
			az_right_q <= 16'sd32767;
			el_lower_q <= -16'sd16384;
			el_upper_q <= 16'sd16384;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_AZ_LEFT:  az_left_q  <= pwdata[15:0];
				REG_AZ_RIGHT: az_right_q <= pwdata[15:0];
				REG_EL_LOWER: el_lower_q <= pwdata[15:0];
				REG_EL_UPPER: el_upper_q <= pwdata[15:0];
				default:      az_left_q  <= az_left_q;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_AZ_LEFT:  prdata = 32'(az_left_q);
			REG_AZ_RIGHT: prdata = 32'(az_right_q);
			REG_EL_LOWER: prdata = 32'(el_lower_q);
			REG_EL_UPPER: prdata = 32'(el_upper_q);
			default:      prdata = '0;
		endcase
	end

	// Input fields.
	logic signed [23:0] rel_north;
	logic signed [23:0] rel_east;
	logic signed [23:0] rel_down;
	logic signed [15:0] heading_sin;
	logic signed [15:0] heading_cos;

	assign rel_north   = s_tdata[23:0];
	assign rel_east    = s_tdata[47:24];
	assign rel_down    = s_tdata[71:48];
	assign heading_sin = s_tdata[87:72];
	assign heading_cos = s_tdata[103:88];

	// Stage 1: the four rotation products and the scaled down offset. The
	// down offset is multiplied by the CORDIC gain so that the elevation
	// vector matches the gain left on the ground range.
	logic               v_s1;
	logic               trk_s1;
	logic signed [39:0] nc_s1;
	logic signed [39:0] es_s1;
	logic signed [39:0] ec_s1;
	logic signed [39:0] ns_s1;
	logic signed [40:0] dz_s1;
	logic               rdy1;

	// Stage 2: heading-frame x and y, and the elevation numerator.
	logic                 v_s2;
	logic                 trk_s2;
	logic signed [CW-1:0] x_s2;
	logic signed [CW-1:0] y_s2;
	logic signed [CW-1:0] zz_s2;
	logic                 rdy2;

	logic                 az_in_ready;
	side_t                az_side_in;

	assign rdy1     = !v_s1 || rdy2;
	assign rdy2     = !v_s2 || az_in_ready;
	assign s_tready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy1) begin
				v_s1 <= s_tvalid;
			end
			if (rdy2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && s_tvalid) begin
			trk_s1 <= s_tuser;
			nc_s1  <= rel_north * heading_cos;
			es_s1  <= rel_east * heading_sin;
			ec_s1  <= rel_east * heading_cos;
			ns_s1  <= rel_north * heading_sin;
			dz_s1  <= rel_down * GAIN_Z_MUL;
		end
		if (rdy2 && v_s1) begin
			trk_s2 <= trk_s1;
			x_s2   <= CW'(nc_s1) + CW'(es_s1);
			y_s2   <= CW'(ec_s1) - CW'(ns_s1);
			zz_s2  <= -CW'(dz_s1);
		end
	end

	assign az_side_in = '{trk: trk_s2, az: 16'h0000, zz: zz_s2};

	// Azimuth CORDIC: the angle of (x, y) and the scaled ground range.
	logic                 az_valid;
	logic                 az_ready;
	logic signed [CW-1:0] az_mag;
	logic [31:0]          az_ang;
	side_t                az_side;

	tpae_cordic u_az (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s2),
		.in_ready (az_in_ready),
		.in_x     (x_s2),
		.in_y     (y_s2),
		.in_side  (az_side_in),
		.out_valid(az_valid),
		.out_ready(az_ready),
		.out_mag  (az_mag),
		.out_ang  (az_ang),
		.out_side (az_side)
	);

	// Elevation CORDIC: the angle of (ground range, -down). The rounded
	// azimuth travels alongside it.
	side_t                el_side_in;
	logic                 el_valid;
	logic                 el_ready;
	logic signed [CW-1:0] el_mag;
	logic [31:0]          el_ang;
	side_t                el_side;

	assign el_side_in = '{trk: az_side.trk, az: to_bau(az_ang), zz: az_side.zz};

	tpae_cordic u_el (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (az_valid),
		.in_ready (az_ready),
		.in_x     (az_mag),
		.in_y     (az_side.zz),
		.in_side  (el_side_in),
		.out_valid(el_valid),
		.out_ready(el_ready),
		.out_mag  (el_mag),
		.out_ang  (el_ang),
		.out_side (el_side)
	);

	// Final stage: saturate the elevation to plus or minus a quarter turn,
	// then clamp both angles to the limits. The lower limit is tested first,
	// so crossed limits resolve in favour of it for values below it.
	logic signed [15:0] el_raw;
	logic signed [15:0] el_sat;
	logic signed [15:0] el_cl;
	logic signed [15:0] az_raw;
	logic signed [15:0] az_cl;
	logic               out_rdy;
	logic               m_tvalid_q;
	logic [31:0]        m_tdata_q;
	logic               m_tuser_q;

	assign el_raw = to_bau(el_ang);
	assign az_raw = el_side.az;

	always_comb begin
		if (el_raw > 16'sd16384) begin
			el_sat = 16'sd16384;
		end else if (el_raw < -16'sd16384) begin
			el_sat = -16'sd16384;
		end else begin
			el_sat = el_raw;
		end

		if (el_sat < el_lower_q) begin
			el_cl = el_lower_q;
		end else if (el_sat > el_upper_q) begin
			el_cl = el_upper_q;
		end else begin
			el_cl = el_sat;
		end

		if (az_raw < az_left_q) begin
			az_cl = az_left_q;
		end else if (az_raw > az_right_q) begin
			az_cl = az_right_q;
		end else begin
			az_cl = az_raw;
		end
	end

	assign out_rdy  = !m_tvalid_q || m_tready;
	assign el_ready = out_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_rdy) begin
			m_tvalid_q <= el_valid;
		end
	end

	// Without a track the angles are zero and the antenna does a bar search.
	always_ff @(posedge clk) begin
		if (out_rdy && el_valid) begin
			if (el_side.trk) begin
				m_tdata_q <= {el_cl, az_cl};
				m_tuser_q <= 1'b0;
			end else begin
				m_tdata_q <= '0;
				m_tuser_q <= 1'b1;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

`ifndef ASSERT_OFF
	// A bar-search result always carries zero angles.
	a_search_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata == 32'h0000_0000))
		else $error("bar search result with non-zero angles");

	// The pipeline only refuses input while the output stage is held.
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready))
		else $error("input refused without output back-pressure");

	// A write to the left azimuth limit lands in the register.
	a_cfg_left: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_wr && (cfg_idx == REG_AZ_LEFT)) |=> (az_left_q == $past(pwdata[15:0])))
		else $error("left azimuth limit write lost");
`endif

endmodule
